[sv/resampling_channel_mixer_macros.svh]
// Assertion macros shared by the checker of the resampling channel mixer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef RESAMPLING_CHANNEL_MIXER_MACROS_SVH
`define RESAMPLING_CHANNEL_MIXER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcm assertion failed");

// Next-cycle implication.
`define RCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcm assertion failed");

`endif

[sv/rcm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the resampling channel mixer.
// No dependencies; the design and checker files refer to it by scoped names, the bench imports it.
package rcm_pkg;

  localparam int PHASE_FRACTION_BITS = 14;
  localparam int MAX_RUN             = 64;

  localparam int PHASE_W  = 19;
  localparam int SAMPLE_W = 16;
  localparam int RAW_W    = 32;
  localparam int MIX_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int OPER_W   = 17;
  localparam int PROD_W   = 2 * OPER_W;
  localparam int RUN_W    = $clog2(MAX_RUN + 1);
  localparam int FMT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRACTION_BITS;
  localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
  localparam logic [GAIN_W-1:0]  UNITY_GAIN = GAIN_W'(8192);

  // sample formats
  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S8  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U16 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT    = 3'd6;

  typedef struct packed {
    logic [RAW_W-1:0] raw_left;
    logic [RAW_W-1:0] raw_right;
  } in_item_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_left;
    logic signed [MIX_W-1:0] mix_right;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [FMT_W-1:0] sample_format;
    logic             byte_swap;
  } conv_cfg_t;

endpackage

[sv/rcm_in_if.sv]
`timescale 1ns / 1ps
// Input frame channel: valid/ready handshake with one source frame.
// Depends on rcm_pkg.
interface rcm_in_if;
  logic             valid;
  logic             ready;
  rcm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/rcm_out_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with one mixed output frame.
// Depends on rcm_pkg.
interface rcm_out_if;
  logic              valid;
  logic              ready;
  rcm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/rcm_convert.sv]
`timescale 1ns / 1ps
// Raw sample to signed 16-bit conversion, with byte swap and saturation.
// Depends on rcm_pkg.
module rcm_convert (
  input  rcm_pkg::conv_cfg_t                   cfg_i,
  input  logic [rcm_pkg::RAW_W-1:0]            raw_i,
  output logic signed [rcm_pkg::SAMPLE_W-1:0]  sample_o
);

  logic [15:0] half_w;
  logic [31:0] word_w;

  assign half_w = cfg_i.byte_swap ? {raw_i[7:0], raw_i[15:8]} : raw_i[15:0];
  assign word_w = cfg_i.byte_swap ?
                  {raw_i[7:0], raw_i[15:8], raw_i[23:16], raw_i[31:24]} : raw_i;

  always_comb begin
    case (cfg_i.sample_format)
      rcm_pkg::FMT_U8:  sample_o = {~raw_i[7], raw_i[6:0], 8'h00};
      rcm_pkg::FMT_S8:  sample_o = {raw_i[7:0], 8'h00};
      rcm_pkg::FMT_U16: sample_o = {~half_w[15], half_w[14:0]};
      rcm_pkg::FMT_S32: begin
        // saturate unless bits 31..15 all agree
        if (!word_w[31] && (|word_w[30:15])) begin
          sample_o = 16'sh7FFF;
        end else if (word_w[31] && !(&word_w[30:15])) begin
          sample_o = 16'sh8000;
        end else begin
          sample_o = word_w[15:0];
        end
      end
      default:          sample_o = half_w;  // signed 16, also unused codes
    endcase
  end

endmodule

[sv/rcm_mult.sv]
`timescale 1ns / 1ps
// Shared signed 17x17 multiplier with a registered product.
// Depends on rcm_pkg.
module rcm_mult (
  input  logic                                  clk_i,
  input  logic signed [rcm_pkg::OPER_W-1:0]     a_i,
  input  logic signed [rcm_pkg::OPER_W-1:0]     b_i,
  output logic signed [rcm_pkg::PROD_W-1:0]     prod_o
);

  logic signed [rcm_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[sv/resampling_channel_mixer.sv]
`timescale 1ns / 1ps
// Sequence per result: CHECK, then IL and IR with interpolation, then GL, GR and EMIT,
// which loads the output register and waits while a held result is not yet taken.
// A new frame is accepted only in IDLE, once the whole run of results for the last one is out;
// the single shared multiplier gives two (hold) or four (interpolate) products per result.
// Reset (rst_ni low, async): registers return to their documented reset values,
// phase = one source step, stored frames zero, output register empty.
module resampling_channel_mixer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  rcm_in_if.sink                             in_i,
  rcm_out_if.source                          out_o
);

  localparam int PFB = rcm_pkg::PHASE_FRACTION_BITS;
  localparam int SW  = rcm_pkg::SAMPLE_W;
  localparam int OW  = rcm_pkg::OPER_W;
  localparam int PW  = rcm_pkg::PHASE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;  // decide whether another result follows
  localparam logic [2:0] S_IL    = 3'd2;  // left slope times phase
  localparam logic [2:0] S_IR    = 3'd3;  // right slope times phase
  localparam logic [2:0] S_GL    = 3'd4;  // left sample times gain
  localparam logic [2:0] S_GR    = 3'd5;  // right sample times gain
  localparam logic [2:0] S_EMIT  = 3'd6;  // load output register, advance phase

  // configuration registers
  logic [rcm_pkg::FMT_W-1:0]   fmt_q;
  logic                        swap_q;
  logic                        stereo_q;
  logic                        interp_q;
  logic [PW-1:0]               step_q;
  logic [rcm_pkg::GAIN_W-1:0]  gain_l_q;
  logic [rcm_pkg::GAIN_W-1:0]  gain_r_q;

  // datapath state
  logic [2:0]                  state_q, state_d;
  logic [PW-1:0]               phase_q, phase_d;
  logic [rcm_pkg::RUN_W-1:0]   run_q, run_d;
  logic signed [SW-1:0]        prev_l_q, prev_r_q, next_l_q, next_r_q;
  logic signed [SW-1:0]        samp_l_q, samp_l_d, samp_r_q, samp_r_d;
  logic signed [rcm_pkg::MIX_W-1:0] mix_l_q, mix_l_d;
  logic                        out_valid_q, out_valid_d;
  rcm_pkg::out_item_t          out_data_q, out_data_d;

  rcm_pkg::conv_cfg_t          conv_cfg;
  logic signed [SW-1:0]        conv_l, conv_r;
  logic signed [OW-1:0]        mul_a, mul_b;
  logic signed [rcm_pkg::PROD_W-1:0] prod;
  logic signed [rcm_pkg::PROD_W-1:0] prod_shr;
  logic signed [SW+1:0]        interp_sum;
  logic signed [SW-1:0]        interp_sat;
  logic [PW:0]                 phase_add;
  logic [PW-1:0]               phase_adv;
  logic                        run_last;
  logic                        load_out;
  logic                        in_xfer;

  assign conv_cfg.sample_format = fmt_q;
  assign conv_cfg.byte_swap     = swap_q;

  rcm_convert u_conv_l (.cfg_i(conv_cfg), .raw_i(in_i.data.raw_left),  .sample_o(conv_l));
  rcm_convert u_conv_r (.cfg_i(conv_cfg), .raw_i(in_i.data.raw_right), .sample_o(conv_r));

  rcm_mult u_mult (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  // prev + floor(slope * phase / ONE), range-limited to 16 bits
  assign prod_shr   = prod >>> PFB;
  assign interp_sum = {{2{(state_q == S_IR) ? prev_l_q[SW-1] : prev_r_q[SW-1]}},
                       (state_q == S_IR) ? prev_l_q : prev_r_q} + prod_shr[SW+1:0];
  always_comb begin
    if (interp_sum > 18'sd32767) begin
      interp_sat = 16'sh7FFF;
    end else if (interp_sum < -18'sd32768) begin
      interp_sat = 16'sh8000;
    end else begin
      interp_sat = interp_sum[SW-1:0];
    end
  end

  // saturating phase advance and end-of-run detection
  assign phase_add = {1'b0, phase_q} + {1'b0, step_q};
  assign phase_adv = phase_add[PW] ? rcm_pkg::PHASE_MAX : phase_add[PW-1:0];
  assign run_last  = (phase_adv >= rcm_pkg::PHASE_ONE) ||
                     (run_q == rcm_pkg::RUN_W'(rcm_pkg::MAX_RUN - 1));

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign load_out    = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_IL: begin
        mul_a = OW'(next_l_q) - OW'(prev_l_q);
        mul_b = OW'(phase_q[PFB-1:0]);
      end
      S_IR: begin
        mul_a = OW'(next_r_q) - OW'(prev_r_q);
        mul_b = OW'(phase_q[PFB-1:0]);
      end
      S_GL: begin
        mul_a = OW'(samp_l_q);
        mul_b = {1'b0, gain_l_q};
      end
      default: begin
        mul_a = OW'(samp_r_q);
        mul_b = {1'b0, gain_r_q};
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    run_d       = run_q;
    samp_l_d    = samp_l_q;
    samp_r_d    = samp_r_q;
    mix_l_d     = mix_l_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          phase_d = (phase_q >= rcm_pkg::PHASE_ONE) ? phase_q - rcm_pkg::PHASE_ONE : '0;
          run_d   = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((phase_q < rcm_pkg::PHASE_ONE) &&
            (run_q != rcm_pkg::RUN_W'(rcm_pkg::MAX_RUN))) begin
          if (interp_q) begin
            state_d = S_IL;
          end else begin
            samp_l_d = prev_l_q;
            samp_r_d = prev_r_q;
            state_d  = S_GL;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IL: state_d = S_IR;
      S_IR: begin
        samp_l_d = interp_sat;
        state_d  = S_GL;
      end
      S_GL: begin
        if (interp_q) begin
          samp_r_d = interp_sat;
        end
        state_d = S_GR;
      end
      S_GR: begin
        mix_l_d = prod[rcm_pkg::MIX_W-1:0];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) begin
          out_valid_d            = 1'b1;
          out_data_d.mix_left    = mix_l_q;
          out_data_d.mix_right   = prod[rcm_pkg::MIX_W-1:0];
          out_data_d.last_of_run = run_last;
          phase_d                = phase_adv;
          run_d                  = run_q + 1'b1;
          state_d                = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= rcm_pkg::FMT_S16;
      swap_q      <= 1'b0;
      stereo_q    <= 1'b0;
      interp_q    <= 1'b0;
      step_q      <= rcm_pkg::PHASE_ONE;
      gain_l_q    <= rcm_pkg::UNITY_GAIN;
      gain_r_q    <= rcm_pkg::UNITY_GAIN;
      state_q     <= S_IDLE;
      phase_q     <= rcm_pkg::PHASE_ONE;
      run_q       <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      next_l_q    <= '0;
      next_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rcm_pkg::CFG_SAMPLE_FORMAT: fmt_q    <= cfg_data_i[rcm_pkg::FMT_W-1:0];
          rcm_pkg::CFG_BYTE_SWAP:     swap_q   <= cfg_data_i[0];
          rcm_pkg::CFG_STEREO:        stereo_q <= cfg_data_i[0];
          rcm_pkg::CFG_INTERPOLATE:   interp_q <= cfg_data_i[0];
          rcm_pkg::CFG_PHASE_STEP:    step_q   <= cfg_data_i[PW-1:0];
          rcm_pkg::CFG_GAIN_LEFT:     gain_l_q <= cfg_data_i[rcm_pkg::GAIN_W-1:0];
          rcm_pkg::CFG_GAIN_RIGHT:    gain_r_q <= cfg_data_i[rcm_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        // frames shift along; mono copies left into right
        prev_l_q <= next_l_q;
        prev_r_q <= next_r_q;
        next_l_q <= conv_l;
        next_r_q <= stereo_q ? conv_r : conv_l;
      end
      state_q     <= state_d;
      phase_q     <= phase_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and output payload, no reset needed
  always_ff @(posedge clk_i) begin
    samp_l_q   <= samp_l_d;
    samp_r_q   <= samp_r_d;
    mix_l_q    <= mix_l_d;
    out_data_q <= out_data_d;
  end

endmodule

[sv/rcm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for resampling_channel_mixer, bound to the top level.
// Depends on rcm_pkg and resampling_channel_mixer_macros.svh.
`include "resampling_channel_mixer_macros.svh"

module rcm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input rcm_pkg::out_item_t out_data_i
);

  // a stalled result stays put
  `RCM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // one frame at a time: busy right after an input transfer
  `RCM_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_i, !in_ready_i)

  // a result that is not last of its run means the run is still going
  `RCM_ASSERT_NOW(a_run_open, out_valid_i && !out_data_i.last_of_run, !in_ready_i)

endmodule

bind resampling_channel_mixer rcm_checker u_rcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for resampling_channel_mixer: directed and random source frames, with the
// expected mixed outputs worked out by an in-bench rate converter model.
// Depends on rcm_pkg, rcm_in_if, rcm_out_if and the block under test.
module tb;
  import rcm_pkg::*;

  // Run limits. The cycle limit covers every frame producing a full capped run with
  // every output waiting out a long sink stall, taken several times over.
  localparam int LIMIT_CYCLES       = 5_000_000;
  localparam int SETTLE_CYCLES      = 24;   // zero-output frames may still be in flight
  localparam int HOLD_CYCLES        = 400;  // long sink stall in the backpressure test
  localparam int REPORT_MAX         = 10;
  localparam int RANDOM_SETTINGS    = 5;
  localparam int FRAMES_PER_SETTING = 17;

  // Format code outside the defined set; the block treats it as signed 16.
  localparam logic [FMT_W-1:0]   FMT_UNDEFINED = 3'd7;
  localparam logic [PHASE_W-1:0] STEP_LOW      = PHASE_W'(256);
  localparam logic [PHASE_W-1:0] STEP_HIGH     = PHASE_W'(262144);
  localparam logic [PHASE_W-1:0] STEP_SLOW     = PHASE_W'(100);  // forces the run cap
  localparam logic [GAIN_W-1:0]  GAIN_FULL     = {GAIN_W{1'b1}};

  typedef struct {
    logic [FMT_W-1:0]   sample_format;
    logic               byte_swap;
    logic               stereo;
    logic               interpolate;
    logic [PHASE_W-1:0] phase_step;
    logic [GAIN_W-1:0]  gain_left;
    logic [GAIN_W-1:0]  gain_right;
  } mixer_setup_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rcm_in_if  frame_ch ();
  rcm_out_if mix_ch ();

  resampling_channel_mixer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (frame_ch),
    .out_o      (mix_ch)
  );

  // Model copy of the registers and of the converter state.
  mixer_setup_t               setup;
  logic [PHASE_W-1:0]         phase;
  logic signed [SAMPLE_W-1:0] prev_l, prev_r, next_l, next_r;

  // Mixed outputs still owed by the block, oldest first.
  out_item_t pending_mix[$];

  int error_count   = 0;
  int cycle_count   = 0;
  int src_idle_pct  = 11;
  int sink_idle_pct = 80;
  bit hold_sink     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Model arithmetic
  // ------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

  // Raw sample bits to signed 16 in the configured format.
  function automatic logic signed [SAMPLE_W-1:0] to_pcm16(logic [RAW_W-1:0] raw,
                                                          mixer_setup_t s);
    logic [15:0] half;
    logic [31:0] word;
    half = s.byte_swap ? {raw[7:0], raw[15:8]} : raw[15:0];
    word = s.byte_swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    case (s.sample_format)
      FMT_U8:  return {raw[7:0] ^ 8'h80, 8'h00};   // 8-bit data ignores the swap
      FMT_S8:  return {raw[7:0], 8'h00};
      FMT_U16: return {~half[15], half[14:0]};     // minus 32768
      FMT_S32: return clamp16(longint'($signed(word)));
      default: return half;                        // signed 16 and undefined codes
    endcase
  endfunction

  // a + floor((b - a) * frac / ONE), saturated.
  function automatic logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                                       logic signed [SAMPLE_W-1:0] b,
                                                       logic [PHASE_W-1:0] frac);
    longint diff;
    diff = (longint'(b) - longint'(a)) * longint'(frac);
    return clamp16(longint'(a) + (diff >>> PHASE_FRACTION_BITS));
  endfunction

  function automatic logic signed [MIX_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] smp,
                                                         logic [GAIN_W-1:0] gain);
    return MIX_W'(longint'(smp) * longint'(gain));
  endfunction

  // Advances the model by one source frame and queues the outputs it causes.
  function automatic void predict_frame(in_item_t item);
    logic signed [SAMPLE_W-1:0] l, r, sl, sr;
    logic [PHASE_W:0]           sum;
    out_item_t                  res;
    int                         count;
    l = to_pcm16(item.raw_left, setup);
    r = setup.stereo ? to_pcm16(item.raw_right, setup) : l;
    // phase below one at input only after a capped run; floor at zero
    phase  = (phase >= PHASE_ONE) ? phase - PHASE_ONE : '0;
    prev_l = next_l;
    prev_r = next_r;
    next_l = l;
    next_r = r;
    count  = 0;
    while (phase < PHASE_ONE && count < MAX_RUN) begin
      if (setup.interpolate) begin
        sl = blend(prev_l, next_l, phase);
        sr = blend(prev_r, next_r, phase);
      end else begin
        sl = prev_l;
        sr = prev_r;
      end
      res.mix_left    = apply_gain(sl, setup.gain_left);
      res.mix_right   = apply_gain(sr, setup.gain_right);
      res.last_of_run = 1'b0;
      pending_mix.push_back(res);
      count++;
      sum   = {1'b0, phase} + {1'b0, setup.phase_step};
      phase = (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[PHASE_W-1:0];
    end
    // mark the tail of the run
    if (count > 0) begin
      res = pending_mix.pop_back();
      res.last_of_run = 1'b1;
      pending_mix.push_back(res);
    end
  endfunction

  // ------------------------------------------------------------------------
  // Monitors. Everything is sampled at the rising edge, before the block's
  // registers update, so the handshake seen is the one completing at that edge.
  // ------------------------------------------------------------------------

  function automatic void flag_error(string what);
    error_count++;
    if (error_count <= REPORT_MAX) $display("%s", what);
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Input transfer: update the model.
  always @(posedge clk_i) begin
    if (rst_ni && frame_ch.valid && frame_ch.ready) predict_frame(frame_ch.data);
  end

  // Output transfer: compare with the oldest owed output.
  always @(posedge clk_i) begin : check_mix
    out_item_t want;
    if (rst_ni && mix_ch.valid && mix_ch.ready) begin
      if (pending_mix.size() == 0) begin
        flag_error($sformatf("unexpected output at cycle %0d: L=%0d R=%0d last=%0b",
                             cycle_count, mix_ch.data.mix_left, mix_ch.data.mix_right,
                             mix_ch.data.last_of_run));
      end else begin
        want = pending_mix.pop_front();
        if (mix_ch.data.mix_left !== want.mix_left ||
            mix_ch.data.mix_right !== want.mix_right ||
            mix_ch.data.last_of_run !== want.last_of_run) begin
          flag_error($sformatf(
            "output mismatch at cycle %0d: want L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
            cycle_count, want.mix_left, want.mix_right, want.last_of_run,
            mix_ch.data.mix_left, mix_ch.data.mix_right, mix_ch.data.last_of_run));
        end
      end
    end
  end

  // Sink side: random stalls, plus a forced hold-off for the backpressure test.
  always @(posedge clk_i) begin
    mix_ch.ready <= !hold_sink && ($urandom_range(99) >= sink_idle_pct);
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  function automatic mixer_setup_t setup_of(logic [FMT_W-1:0] fmt, logic swap, logic st,
                                            logic ip, logic [PHASE_W-1:0] step,
                                            logic [GAIN_W-1:0] gl, logic [GAIN_W-1:0] gr);
    mixer_setup_t s;
    s.sample_format = fmt;
    s.byte_swap     = swap;
    s.stereo        = st;
    s.interpolate   = ip;
    s.phase_step    = step;
    s.gain_left     = gl;
    s.gain_right    = gr;
    return s;
  endfunction

  function automatic in_item_t frame_of(logic [RAW_W-1:0] l, logic [RAW_W-1:0] r);
    in_item_t f;
    f.raw_left  = l;
    f.raw_right = r;
    return f;
  endfunction

  // Mostly full-width noise; some values near the 16-bit range so that
  // 32-bit data also lands between the saturation points.
  function automatic logic [RAW_W-1:0] random_raw();
    if ($urandom_range(9) < 3) return RAW_W'(int'($urandom_range(80000)) - 40000);
    return $urandom();
  endfunction

  function automatic in_item_t random_frame();
    return frame_of(random_raw(), random_raw());
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return GAIN_FULL;
      default: return GAIN_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic mixer_setup_t random_setup();
    mixer_setup_t s;
    s.sample_format = FMT_W'($urandom_range(7));
    s.byte_swap     = 1'($urandom_range(1));
    s.stereo        = 1'($urandom_range(1));
    s.interpolate   = 1'($urandom_range(1));
    // mostly near unity ratio; sometimes up- or down-sampling hard
    case ($urandom_range(3))
      0:       s.phase_step = PHASE_W'($urandom_range(int'(STEP_LOW), int'(PHASE_ONE) / 4));
      3:       s.phase_step = PHASE_W'($urandom_range(int'(PHASE_ONE), int'(STEP_HIGH)));
      default: s.phase_step = PHASE_W'($urandom_range(int'(PHASE_ONE) / 4,
                                                      4 * int'(PHASE_ONE)));
    endcase
    s.gain_left  = random_gain();
    s.gain_right = random_gain();
    return s;
  endfunction

  // Offers one frame and returns at the edge where it transfers. Valid stays up
  // so that a following frame goes back to back.
  task automatic send_frame(in_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data  <= item;
    do @(posedge clk_i); while (!frame_ch.ready);
  endtask

  // Waits until every owed output has arrived and trailing frames have settled.
  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Writes every register once the block is idle.
  task automatic apply_setup(mixer_setup_t s);
    wait_idle();
    put_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'(s.sample_format));
    put_reg(CFG_BYTE_SWAP,     CFG_DATA_W'(s.byte_swap));
    put_reg(CFG_STEREO,        CFG_DATA_W'(s.stereo));
    put_reg(CFG_INTERPOLATE,   CFG_DATA_W'(s.interpolate));
    put_reg(CFG_PHASE_STEP,    CFG_DATA_W'(s.phase_step));
    put_reg(CFG_GAIN_LEFT,     CFG_DATA_W'(s.gain_left));
    put_reg(CFG_GAIN_RIGHT,    CFG_DATA_W'(s.gain_right));
    cfg_we_i <= 1'b0;
    setup = s;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Register reset values: signed 16 mono, hold, unit step, unity gain.
  task automatic test_reset_defaults();
    send_frame(frame_of(32'h0000_7FFF, 32'h1234_5678));
    send_frame(frame_of(32'hFFFF_8000, 32'h0000_0000));
    send_frame(frame_of(32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Every defined format code and one undefined code, both swap settings seen, stereo, half-step
  // interpolation. Unsigned 8 runs with swap set, which must have no effect.
  task automatic test_sample_formats();
    logic [FMT_W-1:0] fmts[6];
    logic             swaps[6];
    fmts  = '{FMT_U8, FMT_S8, FMT_S16, FMT_U16, FMT_S32, FMT_UNDEFINED};
    swaps = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    for (int i = 0; i < 6; i++) begin
      apply_setup(setup_of(fmts[i], swaps[i], 1'b1, 1'b1, PHASE_ONE >> 1,
                           UNITY_GAIN, GAIN_FULL));
      send_frame(frame_of(32'h0000_807F, 32'hFFFF_7F80));
      send_frame(frame_of(32'h7FFF_FFFF, 32'h8000_0000));
    end
  endtask

  // Sink holds off for a long stretch while frames keep coming, so the block
  // fills and stalls its input.
  task automatic test_backpressure();
    apply_setup(setup_of(FMT_S16, 1'b0, 1'b1, 1'b1, PHASE_ONE >> 1,
                         UNITY_GAIN, UNITY_GAIN));
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_sink <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_sink <= 1'b0;
      end
      repeat (30) send_frame(random_frame());
    join
  endtask

  // Step too small to reach one within a run: 64 outputs, the phase stays below
  // one and the next frame floors it at zero. A zero step repeats one sample.
  task automatic test_run_cap();
    apply_setup(setup_of(FMT_S16, 1'b0, 1'b0, 1'b1, STEP_SLOW, UNITY_GAIN, UNITY_GAIN));
    send_frame(frame_of(32'h0000_4000, 32'h0));
    send_frame(frame_of(32'h0000_C000, 32'h0));
    apply_setup(setup_of(FMT_S16, 1'b0, 1'b0, 1'b1, '0, GAIN_FULL, GAIN_FULL));
    send_frame(frame_of(32'h0000_7FFF, 32'h0));
  endtask

  // Largest step saturates the phase; the frames after it cause no output.
  task automatic test_phase_overflow();
    apply_setup(setup_of(FMT_S16, 1'b0, 1'b1, 1'b1, PHASE_MAX, '0, GAIN_FULL));
    send_frame(frame_of(32'h0000_8000, 32'h0000_7FFF));
    send_frame(frame_of(32'h0000_1111, 32'h0000_2222));
    send_frame(frame_of(32'h0000_3333, 32'h0000_4444));
    send_frame(frame_of(32'h0000_5555, 32'h0000_6666));
  endtask

  // Random settings and frames; the first two settings take the step extremes.
  task automatic test_random_traffic(int src_pct, int sink_pct);
    mixer_setup_t s;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    for (int k = 0; k < RANDOM_SETTINGS; k++) begin
      s = random_setup();
      if (k == 0) s.phase_step = STEP_LOW;
      if (k == 1) s.phase_step = STEP_HIGH;
      apply_setup(s);
      repeat (FRAMES_PER_SETTING) send_frame(random_frame());
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    frame_ch.valid = 1'b0;
    frame_ch.data  = '0;
    mix_ch.ready   = 1'b0;
    setup  = setup_of(FMT_S16, 1'b0, 1'b0, 1'b0, PHASE_ONE, UNITY_GAIN, UNITY_GAIN);
    phase  = PHASE_ONE;
    prev_l = '0;
    prev_r = '0;
    next_l = '0;
    next_r = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_sample_formats();
    test_backpressure();
    src_idle_pct = 11;
    sink_idle_pct <= 80;
    test_run_cap();
    test_phase_overflow();
    test_random_traffic(11, 80);
    test_random_traffic(80, 11);
    test_random_traffic(0, 0);
    wait_idle();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
